// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the hash engine files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/shash_pkg.sv -----
package shash_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  valid_bytes;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_done;
   } rsp_type;

   // One word handed from the front end to the compression back end.
   typedef struct packed {
      logic [31:0] data;
      logic        start;  // first word of a message: reload chain
      logic        algo;   // 1 selects SHA-256
      logic        last;   // last word of the padded message
   } blk_word_type;

   localparam int QueueDepth = 4;

   localparam logic [31:0] Sha1K0 = 32'h5a827999;
   localparam logic [31:0] Sha1K1 = 32'h6ed9eba1;
   localparam logic [31:0] Sha1K2 = 32'h8f1bbcdc;
   localparam logic [31:0] Sha1K3 = 32'hca62c1d6;
   localparam logic [7:0]  PadByte = 8'h80;

   function automatic logic [31:0] iv_word(input logic algo, input logic [2:0] idx);
      logic [31:0] r;
      r = 32'h0;
      if (algo) begin
         case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
         endcase
      end else begin
         case (idx)
            3'd0: r = 32'h67452301;
            3'd1: r = 32'hefcdab89;
            3'd2: r = 32'h98badcfe;
            3'd3: r = 32'h10325476;
            3'd4: r = 32'hc3d2e1f0;
            default: r = 32'h0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [31:0] k256(input logic [5:0] i);
      logic [31:0] t [64];
      t = '{
         32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
         32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
         32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
         32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
         32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
         32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
         32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
         32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
         32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
         32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
         32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return t[i];
   endfunction

endpackage

// ----- rtl/core/shash_pad.sv -----
`include "assert_macros.svh"
// Front end: accept message words, count bits, emit the padded word stream.
module shash_pad (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_hash_select,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  shash_pkg::req_type     req_data,
   output logic                   q_valid,
   input  logic                   q_stall,
   output shash_pkg::blk_word_type q_data
);
   localparam logic [1:0] PS_IDLE = 2'd0;  // take message words
   localparam logic [1:0] PS_PAD  = 2'd1;  // emit zero words
   localparam logic [1:0] PS_LENH = 2'd2;
   localparam logic [1:0] PS_LENL = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [63:0] len_ff, len_in;
   logic [3:0]  fill_ff, fill_in;
   logic        busy_ff, busy_in;
   logic        algo_ff, algo_in;
   logic        extra_ff, extra_in;  // full final word: next word is the pad marker
   logic [2:0]  vb;
   logic [31:0] mask, marker, w;
   logic        emit, algo_now, start_now;

   assign algo_now  = busy_ff ? algo_ff : csr_hash_select;
   assign start_now = !busy_ff;
   assign emit      = q_valid && !q_stall;
   assign req_stall = (state_ff != PS_IDLE) || extra_ff || q_stall;

   always_comb begin
      vb = (!req_data.final_word || req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
      mask = (vb == 3'd0) ? 32'h0 : (32'hffffffff << {(3'd4 - vb), 3'b000});
      marker = (vb == 3'd4) ? 32'h0 :
               ({24'h0, shash_pkg::PadByte} << {(3'd3 - vb[1:0]), 3'b000});
      w = (req_data.message_word & mask) | marker;
   end

   always_comb begin
      q_valid = 1'b0;
      q_data  = '0;
      q_data.algo = algo_now;
      if (extra_ff) begin
         q_valid = 1'b1;
         q_data.data = {shash_pkg::PadByte, 24'h0};
      end else begin
         case (state_ff)
            PS_IDLE: begin
               q_valid = req_valid;
               q_data.data = w;
               q_data.start = start_now;
            end
            PS_PAD:  q_valid = 1'b1;
            PS_LENH: begin
               q_valid = 1'b1;
               q_data.data = len_ff[63:32];
            end
            PS_LENL: begin
               q_valid = 1'b1;
               q_data.data = len_ff[31:0];
               q_data.last = 1'b1;
            end
            default: q_valid = 1'b0;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      busy_in  = busy_ff;
      algo_in  = algo_ff;
      extra_in = extra_ff;
      if (emit) begin
         fill_in = fill_ff + 4'd1;
         if (extra_ff) begin
            extra_in = 1'b0;
            state_in = (fill_ff == 4'd13) ? PS_LENH : PS_PAD;
         end else begin
            case (state_ff)
               PS_IDLE: begin
                  busy_in = 1'b1;
                  algo_in = algo_now;
                  len_in  = (start_now ? 64'd0 : len_ff) + {58'd0, vb, 3'b000};
                  if (req_data.final_word) begin
                     if (vb == 3'd4) extra_in = 1'b1;
                     else state_in = (fill_ff == 4'd13) ? PS_LENH : PS_PAD;
                  end
                  if (start_now) fill_in = 4'd1;
               end
               PS_PAD:  if (fill_ff == 4'd13) state_in = PS_LENH;
               PS_LENH: state_in = PS_LENL;
               PS_LENL: begin
                  state_in = PS_IDLE;
                  busy_in  = 1'b0;
                  fill_in  = 4'd0;
               end
               default: state_in = PS_IDLE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PS_IDLE;
         len_ff   <= 64'd0;
         fill_ff  <= 4'd0;
         busy_ff  <= 1'b0;
         algo_ff  <= 1'b1;
         extra_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         busy_ff  <= busy_in;
         algo_ff  <= algo_in;
         extra_ff <= extra_in;
      end
   end

   `ASSERT_IMPLY(a_len_slot, clock, reset, state_ff == PS_LENH, fill_ff == 4'd14 && !extra_ff, "length high word off slot 14")
   `ASSERT_IMPLY(a_last_end, clock, reset, q_valid && q_data.last, fill_ff == 4'd15, "last word not at block end")
   `ASSERT_NEXT(a_idle_after, clock, reset, emit && q_data.last, state_ff == PS_IDLE && !busy_ff, "no return to idle")
endmodule

// ----- rtl/core/shash_fifo.sv -----
`include "assert_macros.svh"
// Short queue between padding front end and compression back end.
module shash_fifo #(
   parameter int Depth = shash_pkg::QueueDepth
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  shash_pkg::blk_word_type in_data,
   output logic                    out_valid,
   input  logic                    out_stall,
   output shash_pkg::blk_word_type out_data
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   shash_pkg::blk_word_type mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic          push, pop;

   assign in_stall  = (cnt_ff == (AW+1)'(Depth));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

   `ASSERT_IMPLY(a_cnt_max, clock, reset, 1'b1, cnt_ff <= (AW+1)'(Depth), "queue overflow")
   `ASSERT_NEXT(a_full_cnt, clock, reset, push && !pop, cnt_ff == $past(cnt_ff) + 1'b1, "missed push")
   `ASSERT_NEXT(a_pop_cnt, clock, reset, pop && !push, cnt_ff == $past(cnt_ff) - 1'b1, "missed pop")
endmodule

// ----- rtl/core/shash_core.sv -----
`include "assert_macros.svh"
// Back end: buffer 16 words, one round a cycle, then stream the digest.
module shash_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_stall,
   input  shash_pkg::blk_word_type q_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output shash_pkg::rsp_type      rsp_data
);
   localparam logic [1:0] CS_FILL = 2'd0;
   localparam logic [1:0] CS_RND  = 2'd1;
   localparam logic [1:0] CS_ADD  = 2'd2;
   localparam logic [1:0] CS_OUT  = 2'd3;

   logic [1:0]  state_ff;
   logic [3:0]  fill_ff;
   logic [6:0]  rnd_ff;
   logic        algo_ff, last_ff;
   logic [2:0]  oidx_ff;
   logic [31:0] chain_ff [8];
   logic [31:0] wk_ff [8];
   logic [31:0] w_ff [16];   // message schedule window
   logic [31:0] wnext, wcur, t1, t2, kk, f, tsha1;
   logic [31:0] s0w, s1w, s0a, s1e, ch, maj;
   logic        take;

   function automatic logic [31:0] rr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   assign take    = (state_ff == CS_FILL) && q_valid;
   assign q_stall = (state_ff != CS_FILL);
   assign wcur    = w_ff[0];

   always_comb begin
      s0w = rr(w_ff[1], 7) ^ rr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w = rr(w_ff[14], 17) ^ rr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      if (algo_ff) wnext = w_ff[0] + s0w + w_ff[9] + s1w;
      else wnext = rr(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 31);
      s1e = rr(wk_ff[4], 6) ^ rr(wk_ff[4], 11) ^ rr(wk_ff[4], 25);
      s0a = rr(wk_ff[0], 2) ^ rr(wk_ff[0], 13) ^ rr(wk_ff[0], 22);
      ch  = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
      maj = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
      t1  = wk_ff[7] + s1e + ch + shash_pkg::k256(rnd_ff[5:0]) + wcur;
      t2  = s0a + maj;
      if (rnd_ff < 7'd20) begin
         f = (wk_ff[1] & wk_ff[2]) | (~wk_ff[1] & wk_ff[3]); kk = shash_pkg::Sha1K0;
      end else if (rnd_ff < 7'd40) begin
         f = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3]; kk = shash_pkg::Sha1K1;
      end else if (rnd_ff < 7'd60) begin
         f = (wk_ff[1] & wk_ff[2]) | (wk_ff[1] & wk_ff[3]) | (wk_ff[2] & wk_ff[3]);
         kk = shash_pkg::Sha1K2;
      end else begin
         f = wk_ff[1] ^ wk_ff[2] ^ wk_ff[3]; kk = shash_pkg::Sha1K3;
      end
      tsha1 = rr(wk_ff[0], 27) + f + wk_ff[4] + kk + wcur;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         w_ff[fill_ff] <= q_data.data;
         if (q_data.start) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= shash_pkg::iv_word(q_data.algo, 3'(i));
         end
      end
      if (state_ff == CS_FILL && take && fill_ff == 4'd15) begin
         for (int i = 0; i < 8; i++) wk_ff[i] <= (q_data.start) ?
            shash_pkg::iv_word(q_data.algo, 3'(i)) : chain_ff[i];
      end
      if (state_ff == CS_RND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnext;
         if (algo_ff) begin
            wk_ff[0] <= t1 + t2; wk_ff[1] <= wk_ff[0]; wk_ff[2] <= wk_ff[1];
            wk_ff[3] <= wk_ff[2]; wk_ff[4] <= wk_ff[3] + t1; wk_ff[5] <= wk_ff[4];
            wk_ff[6] <= wk_ff[5]; wk_ff[7] <= wk_ff[6];
         end else begin
            wk_ff[0] <= tsha1; wk_ff[1] <= wk_ff[0]; wk_ff[2] <= rr(wk_ff[1], 2);
            wk_ff[3] <= wk_ff[2]; wk_ff[4] <= wk_ff[3];
         end
      end
      if (state_ff == CS_ADD) begin
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + wk_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_FILL;
         fill_ff  <= 4'd0;
         rnd_ff   <= 7'd0;
         algo_ff  <= 1'b1;
         last_ff  <= 1'b0;
         oidx_ff  <= 3'd0;
      end else begin
         case (state_ff)
            CS_FILL: if (take) begin
               fill_ff <= fill_ff + 4'd1;
               algo_ff <= q_data.algo;
               if (fill_ff == 4'd15) begin
                  last_ff  <= q_data.last;
                  rnd_ff   <= 7'd0;
                  state_ff <= CS_RND;
               end
            end
            CS_RND: begin
               rnd_ff <= rnd_ff + 7'd1;
               if (rnd_ff == (algo_ff ? 7'd63 : 7'd79)) state_ff <= CS_ADD;
            end
            CS_ADD: begin
               oidx_ff  <= 3'd0;
               state_ff <= last_ff ? CS_OUT : CS_FILL;
            end
            CS_OUT: if (!rsp_stall) begin
               oidx_ff <= oidx_ff + 3'd1;
               if (rsp_data.digest_done) state_ff <= CS_FILL;
            end
            default: state_ff <= CS_FILL;
         endcase
      end
   end

   assign rsp_valid = (state_ff == CS_OUT);
   always_comb begin
      rsp_data.digest_word  = chain_ff[oidx_ff];
      rsp_data.digest_index = oidx_ff;
      rsp_data.digest_done  = (oidx_ff == (algo_ff ? 3'd7 : 3'd4));
   end

   `ASSERT_IMPLY(a_no_take, clock, reset, state_ff != CS_FILL, !take, "word taken mid compression")
   `ASSERT_IMPLY(a_rnd_rng, clock, reset, state_ff == CS_RND, rnd_ff < 7'd80, "round count out of range")
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(oidx_ff), "output index moved under stall")
endmodule

// ----- rtl/core/sha1_sha256_hash_engine.sv -----
// channel | ports                           | direction
// req     | req_valid req_stall req_data    | message words in
// rsp     | rsp_valid rsp_stall rsp_data    | digest words out
// csr     | csr_write csr_data              | hash select (0 SHA-1, 1 SHA-256)
// Each 16-word block is filled into the back end, then runs 64 (SHA-256) or 80 (SHA-1)
// rounds on the single round unit, and is then added into the chaining value.
// The final word adds the pad marker, zero fill and both length words, possibly in an
// extra block, then 5 or 8 digest words. Synchronous reset clears all control state.
// The front end keeps accepting into a 4-entry queue while rounds run.
module sha1_sha256_hash_engine #(
   parameter int QueueDepth = shash_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  shash_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output shash_pkg::rsp_type  rsp_data
);
   logic sel_ff;
   logic a_valid, a_stall, b_valid, b_stall;
   shash_pkg::blk_word_type a_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) sel_ff <= 1'b1;
      else if (csr_write) sel_ff <= csr_data;
   end

   shash_pad u_pad (
      .clock, .reset, .csr_hash_select(sel_ff),
      .req_valid, .req_stall, .req_data,
      .q_valid(a_valid), .q_stall(a_stall), .q_data(a_data));

   shash_fifo #(.Depth(QueueDepth)) u_fifo (
      .clock, .reset,
      .in_valid(a_valid), .in_stall(a_stall), .in_data(a_data),
      .out_valid(b_valid), .out_stall(b_stall), .out_data(b_data));

   shash_core u_core (
      .clock, .reset,
      .q_valid(b_valid), .q_stall(b_stall), .q_data(b_data),
      .rsp_valid, .rsp_stall, .rsp_data);
endmodule

// ----- dv/sha1_sha256_hash_engine_checker.sv -----
module sha1_sha256_hash_engine_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic                          csr_data,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  shash_pkg::req_type            req_data,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  shash_pkg::rsp_type            rsp_data,
   output int                            error_count,
   output int                            pending
);
   localparam logic [31:0] Sha1Iv [5] = '{32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                          32'h10325476, 32'hc3d2e1f0};
   localparam logic [31:0] Sha256Iv [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
                                            32'ha54ff53a, 32'h510e527f, 32'h9b05688c,
                                            32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   logic [31:0]        chain [8];
   logic [31:0]        block_words [16];
   logic [63:0]        msg_bits;
   int                 fill;
   logic               in_message;
   logic               msg_sha256;
   logic               select_sha256;
   shash_pkg::rsp_type digest_q [$];

   function automatic logic [31:0] rol(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic compress_sha1();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 80; i++) w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = shash_pkg::Sha1K0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = shash_pkg::Sha1K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = shash_pkg::Sha1K2;
         end else begin
            f = b ^ c ^ d; k = shash_pkg::Sha1K3;
         end
         t = rol(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   task automatic compress_sha256();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, ch, maj;
      for (int i = 0; i < 16; i++) w[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
         s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int i = 0; i < 64; i++) begin
         s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + RoundK[i] + w[i];
         s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
         maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + s0 + maj;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
   endtask

   task automatic absorb(input logic [31:0] w);
      block_words[fill] = w;
      fill = (fill + 1) % 16;
      if (fill == 0) begin
         if (msg_sha256) compress_sha256();
         else compress_sha1();
      end
   endtask

   task automatic take_request(input shash_pkg::req_type r);
      shash_pkg::rsp_type d;
      int                 nbytes;
      int                 nwords;
      logic [31:0]        mask;
      if (!in_message) begin
         in_message = 1'b1;
         msg_sha256 = select_sha256;
         for (int i = 0; i < 8; i++)
            chain[i] = msg_sha256 ? Sha256Iv[i] : (i < 5 ? Sha1Iv[i] : 32'h0);
         msg_bits = '0;
         fill = 0;
      end
      nbytes = (!r.final_word || r.valid_bytes > 3'd4) ? 4 : int'(r.valid_bytes);
      if (!r.final_word) begin
         msg_bits += 64'd32;
         absorb(r.message_word);
         return;
      end
      msg_bits += 64'(8 * nbytes);
      if (nbytes == 4) begin
         absorb(r.message_word);
         absorb(32'h8000_0000);
      end else begin
         mask = (nbytes == 0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - nbytes)));
         absorb((r.message_word & mask) | (32'(shash_pkg::PadByte) << (8 * (3 - nbytes))));
      end
      // length no longer fits: close this block first
      if (fill > 14) while (fill != 0) absorb(32'h0);
      while (fill < 14) absorb(32'h0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      nwords = msg_sha256 ? 8 : 5;
      for (int i = 0; i < nwords; i++) begin
         d.digest_word  = chain[i];
         d.digest_index = 3'(i);
         d.digest_done  = (i == nwords - 1);
         digest_q = {digest_q, d};
      end
      in_message = 1'b0;
   endtask

   always @(posedge clock) begin
      shash_pkg::rsp_type want;
      if (reset) begin
         select_sha256 = 1'b1;
         in_message = 1'b0;
         msg_sha256 = 1'b1;
         fill = 0;
         msg_bits = '0;
         digest_q.delete();
         error_count = 0;
      end else begin
         if (csr_write) select_sha256 = csr_data;
         if (req_valid && !req_stall) take_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (digest_q.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("digest word %h index %0d with no request pending",
                           rsp_data.digest_word, rsp_data.digest_index);
            end else begin
               want = digest_q.pop_front();
               if (rsp_data.digest_word !== want.digest_word ||
                   rsp_data.digest_index !== want.digest_index ||
                   rsp_data.digest_done !== want.digest_done) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("digest mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                              want.digest_word, want.digest_index, want.digest_done,
                              rsp_data.digest_word, rsp_data.digest_index,
                              rsp_data.digest_done);
               end
            end
         end
      end
      pending = digest_q.size();
   end

endmodule

// ----- dv/sha1_sha256_hash_engine_test.sv -----
module sha1_sha256_hash_engine_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write = 1'b0;
   logic               csr_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   shash_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   shash_pkg::rsp_type rsp_data;
   int                 error_count;
   int                 pending;
   logic               no_gaps = 1'b0;
   int                 n_requests = 0;
   int                 n_messages = 0;
   int                 n_sha1 = 0;

   always #10 clock = ~clock;

   sha1_sha256_hash_engine i_dut (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

   sha1_sha256_hash_engine_checker i_checker (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .error_count(error_count), .pending(pending));

   task automatic send(input logic [31:0] w, input logic [2:0] vb, input logic fin);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= '{message_word: w, valid_bytes: vb, final_word: fin};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      n_requests++;
      if (fin) n_messages++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Write the hash select only once the engine has gone quiet.
   task automatic set_select(input logic sha256);
      drain();
      csr_write <= 1'b1;
      csr_data <= sha256;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic send_message(input int nwords);
      for (int i = 0; i < nwords - 1; i++)
         send($urandom, 3'($urandom_range(0, 7)), 1'b0);
      send($urandom, 3'($urandom_range(0, 7)), 1'b1);
   endtask

   // Hold off digest words at random.
   initial begin
      int hold;
      forever begin
         hold = no_gaps ? 0 : $urandom_range(0, 14);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #20_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int nwords;
      logic sha256;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // SHA-256 out of reset: empty message, full final word, masked short words, over-length byte count
      send(32'h0, 3'd0, 1'b1);
      send(32'hffff_ffff, 3'd4, 1'b1);
      send(32'hffff_ffff, 3'd2, 1'b0);
      send(32'hffff_ffff, 3'd1, 1'b1);
      send(32'h0, 3'd7, 1'b1);
      send(32'h6162_6300, 3'd3, 1'b1);
      set_select(1'b0);
      n_sha1++;
      send(32'h0, 3'd0, 1'b1);
      send(32'h6162_6300, 3'd3, 1'b1);
      send(32'hffff_ffff, 3'd5, 1'b0);
      send(32'h8000_0001, 3'd6, 1'b1);
      send(32'hffff_ffff, 3'd4, 1'b1);
      // fourteen words: length still fits in the same block
      for (int i = 0; i < 13; i++) send(32'h0101_0101 * i, 3'd4, 1'b0);
      send(32'hdead_beef, 3'd2, 1'b1);
      set_select(1'b1);

      while (n_requests < 260) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 3))
            0: nwords = $urandom_range(13, 17);
            1: nwords = $urandom_range(1, 4);
            2: nwords = $urandom_range(28, 34);
            default: nwords = $urandom_range(1, 16);
         endcase
         send_message(nwords);
         if ($urandom_range(0, 3) == 0) begin
            sha256 = 1'($urandom_range(0, 1));
            set_select(sha256);
            if (!sha256) n_sha1++;
         end
      end
      no_gaps = 1'b0;
      drain();
      $display("%0d requests in %0d messages, select written to SHA-1 %0d times;",
               n_requests, n_messages, n_sha1);
      $display("short, over-length and boundary final words under random stalls on both sides");
      if (error_count == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
